[rtl/cqfs_pkg.sv]
// Shared types and constants for the cable QAM frame sync inserter.
// No dependencies; imported by every module of the block.
`default_nettype none
package cqfs_pkg;

  localparam int unsigned SYM_W   = 7;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned TRL_W   = 42;
  localparam int unsigned SHR_W   = SYM_W + TRL_W;
  localparam int unsigned REM_W   = 6;

  localparam logic [CNT_W-1:0] FRAME_LEN_64  = 14'd7680;
  localparam logic [CNT_W-1:0] FRAME_LEN_256 = 14'd11264;

  localparam logic [REM_W-1:0] BITS_SYM      = 6'd7;
  localparam logic [REM_W-1:0] BITS_END_64   = 6'd49;
  localparam logic [REM_W-1:0] BITS_END_256  = 6'd47;

  localparam logic MODE_64  = 1'b0;
  localparam logic MODE_256 = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_QAM_MODE = 1'b0;
  localparam logic REG_CTRL_WORD = 1'b1;

  // Sync groups for 64-QAM (7 bits of each byte) and the 256-QAM word
  localparam logic [6:0]  SYNC64_0 = 7'h75;
  localparam logic [6:0]  SYNC64_1 = 7'h2c;
  localparam logic [6:0]  SYNC64_2 = 7'h0d;
  localparam logic [6:0]  SYNC64_3 = 7'h6c;
  localparam logic [31:0] SYNC256  = 32'h71e84dd4;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             frame_end;
    logic             mode;
  } entry_t;

  // Trailer left-aligned in TRL_W bits, first bit sent in the top bit
  function automatic logic [TRL_W-1:0] trailer(input logic mode, input logic [3:0] cw);
    logic [TRL_W-1:0] t;
    if (mode == MODE_256) begin
      t = {SYNC256, cw, 4'b0000, 2'b00};
    end else begin
      t = {SYNC64_0, SYNC64_1, SYNC64_2, SYNC64_3, cw, 10'b0};
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/cqfs_front.sv]
// Front end: accepts symbol beats, keeps the frame symbol count and tags frame ends.
// Depends on cqfs_pkg.
`default_nettype none
module cqfs_front
  import cqfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             qam_mode,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [SYM_W-1:0] s_symbol,
  input  wire logic             q_full,
  output logic                  q_push,
  output entry_t                q_data
);

  logic [CNT_W-1:0] symbol_count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] frame_len;
  logic             frame_end;

  assign s_tready  = !q_full;
  assign q_push    = s_tvalid && !q_full;
  assign count_inc = symbol_count + 1'b1;
  assign frame_len = (qam_mode == MODE_256) ? FRAME_LEN_256 : FRAME_LEN_64;
  assign frame_end = (count_inc >= frame_len);

  always_comb begin
    q_data.symbol    = s_symbol;
    q_data.frame_end = frame_end;
    q_data.mode      = qam_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
    end else if (q_push) begin
      symbol_count <= frame_end ? '0 : count_inc;
    end
  end

endmodule
`default_nettype wire

[rtl/cqfs_fifo.sv]
// Short queue of tagged symbols between the front end and the serialiser.
// Depends on cqfs_pkg for the entry type.
`default_nettype none
module cqfs_fifo
  import cqfs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      pop_data,
  output logic        valid
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W2 = $clog2(DEPTH + 1);
  localparam logic [CNT_W2-1:0] DEPTH_C = CNT_W2'(DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);

  entry_t             store [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W2-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full     = (fill == DEPTH_C);
  assign valid    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cqfs_back.sv]
// Back end: serialises a symbol, plus its sync trailer at a frame end, one bit a beat.
// Depends on cqfs_pkg.
`default_nettype none
module cqfs_back
  import cqfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] ctrl_word,
  input  wire logic       q_valid,
  input  wire entry_t     q_data,
  output logic            q_pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic            m_bit,
  output logic            m_tlast
);

  logic [SHR_W-1:0] shreg;
  logic [REM_W-1:0] remaining;
  logic             busy;
  logic             take;
  logic             last_beat;
  logic [REM_W-1:0] load_len;

  assign take      = busy && m_tready;
  assign last_beat = (remaining == 6'd1);
  assign q_pop     = q_valid && (!busy || (take && last_beat));
  assign m_tvalid  = busy;
  assign m_bit     = shreg[SHR_W-1];
  assign m_tlast   = last_beat;

  always_comb begin
    if (!q_data.frame_end) begin
      load_len = BITS_SYM;
    end else if (q_data.mode == MODE_256) begin
      load_len = BITS_END_256;
    end else begin
      load_len = BITS_END_64;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shreg <= {q_data.symbol, trailer(q_data.mode, ctrl_word)};
    end else if (take) begin
      shreg <= {shreg[SHR_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (q_pop) begin
      busy      <= 1'b1;
      remaining <= load_len;
    end else if (take) begin
      remaining <= remaining - 1'b1;
      if (last_beat) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cable_qam_frame_sync_inserter.sv]
// Top level of the cable QAM frame sync inserter: config registers, front, queue, back.
// Depends on cqfs_pkg, cqfs_front, cqfs_fifo and cqfs_back.
`default_nettype none
// Each accepted symbol beat gives 7 output bit beats, MSB first; the symbol that ends
// a frame (7680 symbols in 64-QAM, 11264 in 256-QAM) gives 49 or 47 beats because the
// sync trailer and control word follow it. The serialiser shift register sends one bit
// per cycle while m_tready is high, with no gap between queued symbols; a queue of
// DEPTH tagged symbols lets input and output stall independently.
// Registers: qam_mode at address 0, frame_control_word at address 4.
module cable_qam_frame_sync_inserter
  import cqfs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [6:0] symbol, [7] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] serial_bit, [7:1] zero
  output logic             m_tlast
);

  logic       qam_mode;
  logic [3:0] frame_control_word;
  logic       cfg_wr;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  entry_t     q_in;
  entry_t     q_out;
  logic       m_bit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qam_mode           <= 1'b0;
      frame_control_word <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_QAM_MODE:  qam_mode <= pwdata[0];
        REG_CTRL_WORD: frame_control_word <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_QAM_MODE:  prdata = {31'b0, qam_mode};
      REG_CTRL_WORD: prdata = {28'b0, frame_control_word};
      default:       prdata = '0;
    endcase
  end

  cqfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .qam_mode (qam_mode),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_symbol (s_tdata[SYM_W-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  cqfs_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  cqfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ctrl_word (frame_control_word),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_bit     (m_bit),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = {7'b0, m_bit};

  // Output idles straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A queued symbol follows the last beat of the previous one with no gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && q_valid) |=> m_tvalid)
    else $error("gap between queued symbols");

  // With nothing queued, the last beat leaves the output idle
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !q_valid) |=> !m_tvalid)
    else $error("output valid with nothing queued");

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for cable_qam_frame_sync_inserter: streams symbols in, checks the
// serial bit stream, including frame sync trailers, against an in-bench predictor.
// Depends on cqfs_pkg and the RTL top level only.
module tb;
  import cqfs_pkg::*;

  localparam int unsigned FRAME_SYMS_64  = 60 * 128;
  localparam int unsigned FRAME_SYMS_256 = 88 * 128;
  localparam logic [27:0] SYNC_64_GROUPS = {7'h75, 7'h2c, 7'h0d, 7'h6c};
  localparam logic [31:0] SYNC_256_WORD  = 32'h71e84dd4;

  localparam int STUCK_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_WITH_GAPS = 40;
  localparam int RAND_PHASES    = 7;
  localparam int PHASE_ITEMS    = 60;
  localparam int PRESSURE_PHASE = 3;

  typedef enum logic [2:0] {
    ROW_SYMBOL, ROW_MODE, ROW_CTRL, ROW_FILL, ROW_TO_FRAME_END
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [13:0] arg;
    logic        typed;
    logic [6:0]  serial_msb;   // expected bits, first one sent on the left
  } stim_row_t;

  typedef struct packed {
    logic serial;
    logic last;
  } out_beat_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SYMBOL,       14'd0,             1'b1, 7'b0000000},
    '{ROW_SYMBOL,       14'd127,           1'b1, 7'b1111111},
    '{ROW_SYMBOL,       14'd64,            1'b1, 7'b1000000},
    '{ROW_SYMBOL,       14'd1,             1'b1, 7'b0000001},
    '{ROW_SYMBOL,       14'd85,            1'b1, 7'b1010101},
    '{ROW_SYMBOL,       14'd42,            1'b1, 7'b0101010},
    '{ROW_SYMBOL,       14'd60,            1'b0, 7'b0000000},
    '{ROW_CTRL,         14'd15,            1'b0, 7'b0000000},
    '{ROW_TO_FRAME_END, 14'd0,             1'b0, 7'b0000000},
    '{ROW_SYMBOL,       14'd0,             1'b1, 7'b0000000},
    '{ROW_MODE,         {13'd0, MODE_256}, 1'b0, 7'b0000000},
    '{ROW_CTRL,         14'd0,             1'b0, 7'b0000000},
    '{ROW_TO_FRAME_END, 14'd0,             1'b0, 7'b0000000},
    '{ROW_SYMBOL,       14'd43,            1'b0, 7'b0000000},
    '{ROW_CTRL,         14'd5,             1'b0, 7'b0000000},
    '{ROW_FILL,         14'd7999,          1'b0, 7'b0000000},
    '{ROW_MODE,         {13'd0, MODE_64},  1'b0, 7'b0000000},
    '{ROW_SYMBOL,       14'd127,           1'b0, 7'b0000000},
    '{ROW_MODE,         {13'd0, MODE_256}, 1'b0, 7'b0000000},
    '{ROW_CTRL,         14'd15,            1'b0, 7'b0000000},
    '{ROW_TO_FRAME_END, 14'd0,             1'b0, 7'b0000000},
    '{ROW_SYMBOL,       14'd85,            1'b1, 7'b1010101}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [6:0] symbol, [7] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] serial_bit, [7:1] zero
  logic        m_tlast;

  // predictor copy of the block's state and registers
  logic        cur_mode = MODE_64;
  logic [3:0]  cur_cw = 4'd0;
  int unsigned frame_count = 0;
  out_beat_t   pending_bits [$];

  int fail_count = 0;
  int stuck_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_request = 1'b0;

  cable_qam_frame_sync_inserter u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned frame_length();
    return (cur_mode == MODE_256) ? FRAME_SYMS_256 : FRAME_SYMS_64;
  endfunction

  function automatic void queue_bits(input logic [47:0] word, input int nbits);
    out_beat_t beat;
    for (int k = nbits - 1; k >= 0; k--) begin
      beat.serial = word[k];
      beat.last   = 1'b0;
      pending_bits.push_back(beat);
    end
  endfunction

  // Symbol bits (unless already queued by hand), then the trailer if the frame closes
  function automatic void predict_symbol_bits(input logic [6:0] sym, input bit with_symbol);
    if (with_symbol) queue_bits({41'd0, sym}, 7);
    if (frame_count + 1 >= frame_length()) begin
      if (cur_mode == MODE_256)
        queue_bits({8'd0, SYNC_256_WORD, cur_cw, 4'd0}, 40);
      else
        queue_bits({6'd0, SYNC_64_GROUPS, cur_cw, 10'd0}, 42);
      frame_count = 0;
    end else begin
      frame_count = frame_count + 1;
    end
    pending_bits[$].last = 1'b1;
  endfunction

  task automatic drive_symbol(input logic [6:0] sym);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, sym};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic offer_symbol(input logic [6:0] sym);
    predict_symbol_bits(sym, 1'b1);
    drive_symbol(sym);
  endtask

  // Run flat out, idling only over the last few symbols
  task automatic run_burst(input int count);
    for (int i = count; i > 0; i--) begin
      tx_gaps = (i <= TAIL_WITH_GAPS);
      rx_gaps = tx_gaps;
      offer_symbol(7'($urandom_range(0, 127)));
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // hold the bus idle between transfers
    @(posedge clk);
  endtask

  task automatic write_setting(input logic reg_idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    drain();
    apb_access(1'b1, {reg_idx, 2'b00}, value, readback);
    apb_access(1'b0, {reg_idx, 2'b00}, 32'd0, readback);
    apb_release();
    if (reg_idx == REG_QAM_MODE) begin
      want     = value & 32'h1;
      cur_mode = value[0];
    end else begin
      want   = value & 32'hf;
      cur_cw = value[3:0];
    end
    if (readback !== want) note_mismatch("register readback", want, readback);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bits.size() == 0) begin
        note_mismatch("beat with nothing pending", 32'd0, {23'd0, m_tlast, m_tdata});
      end else begin
        want = pending_bits.pop_front();
        if (m_tdata !== {7'd0, want.serial})
          note_mismatch("serial bit", {31'd0, want.serial}, {24'd0, m_tdata});
        if (m_tlast !== want.last)
          note_mismatch("last of run", {31'd0, want.last}, {31'd0, m_tlast});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
  end

  initial begin : rx_side
    int stall;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 99) < 10) begin
        stall = pick_gap();
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : tx_side
    stim_row_t   row;
    logic [31:0] mode_rd;
    logic [31:0] cw_rd;
    logic        mode_pick;
    logic [3:0]  cw_pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_access(1'b0, {REG_QAM_MODE, 2'b00}, 32'd0, mode_rd);
    apb_access(1'b0, {REG_CTRL_WORD, 2'b00}, 32'd0, cw_rd);
    apb_release();
    if (mode_rd !== 32'd0) note_mismatch("qam_mode after reset", 32'd0, mode_rd);
    if (cw_rd !== 32'd0) note_mismatch("control word after reset", 32'd0, cw_rd);

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      case (row.kind)
        ROW_SYMBOL: begin
          if (row.typed) begin
            queue_bits({41'd0, row.serial_msb}, 7);
            predict_symbol_bits(row.arg[6:0], 1'b0);
          end else begin
            predict_symbol_bits(row.arg[6:0], 1'b1);
          end
          drive_symbol(row.arg[6:0]);
        end
        ROW_MODE:         write_setting(REG_QAM_MODE, {18'd0, row.arg});
        ROW_CTRL:         write_setting(REG_CTRL_WORD, {18'd0, row.arg});
        ROW_FILL:         run_burst(row.arg);
        ROW_TO_FRAME_END: run_burst(frame_length() - frame_count);
        default: ;
      endcase
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode_pick = (ph == 0) ? MODE_64 : (ph == 1) ? MODE_256 : 1'($urandom_range(0, 1));
      cw_pick   = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom_range(0, 15));
      write_setting(REG_QAM_MODE, {31'd0, mode_pick});
      write_setting(REG_CTRL_WORD, {28'd0, cw_pick});
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if (ph == PRESSURE_PHASE) begin
        // keep offering while the output is held off so the queue backs up
        tx_gaps = 1'b0;
        hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) offer_symbol(7'($urandom_range(0, 127)));
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cqfs_pkg.sv
rtl/cqfs_front.sv
rtl/cqfs_fifo.sv
rtl/cqfs_back.sv
rtl/cable_qam_frame_sync_inserter.sv
bench/tb.sv
